>>> rtl/core/positional_array_list_defines.svh
// assertion macros for the positional array list
// no dependencies; included by the top level
`ifndef POSITIONAL_ARRAY_LIST_DEFINES_SVH
`define POSITIONAL_ARRAY_LIST_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication under synchronous reset
`define PAL_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pal assertion failed");
// next-cycle implication under synchronous reset
`define PAL_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pal assertion failed");
`else
`define PAL_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define PAL_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

>>> rtl/core/pal_pkg.sv
// shared types and constants for the positional array list
// no dependencies; used by the interfaces, the cell and the top level
package pal_pkg;

  localparam int OP_W  = 2;
  localparam int VAL_W = 32;
  localparam int POS_W = 7;
  localparam int ST_W  = 3;
  localparam int IDX_W = 6;

  typedef enum logic [OP_W-1:0] {
    OP_CREATE  = 2'd0,
    OP_DISPLAY = 2'd1,
    OP_INSERT  = 2'd2,
    OP_DELETE  = 2'd3
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK          = 3'd0,
    ST_NOT_CREATED = 3'd1,
    ST_ALREADY     = 3'd2,
    ST_BAD_POS     = 3'd3,
    ST_EMPTY       = 3'd4,
    ST_FULL        = 3'd5
  } status_t;

  // what every cell of the chain does this cycle
  typedef enum logic [1:0] {
    ACT_HOLD,
    ACT_INSERT,
    ACT_DELETE,
    ACT_ROTATE
  } act_t;

  typedef struct packed {
    act_t              act;
    logic [POS_W-1:0]  pos;
    logic [VAL_W-1:0]  value;
  } cell_cmd_t;

endpackage

>>> rtl/core/pal_in_if.sv
// input channel of the positional array list: valid, ready, one operation
// depends on pal_pkg
interface pal_in_if import pal_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [OP_W-1:0]         operation;
  logic signed [VAL_W-1:0] value;
  logic [POS_W-1:0]        position;
  logic                    last_of_set;
  logic                    no_element;

  modport source (output valid, operation, value, position, last_of_set, no_element,
                  input ready);
  modport sink   (input valid, operation, value, position, last_of_set, no_element,
                  output ready);
endinterface

>>> rtl/core/pal_out_if.sv
// result channel of the positional array list: valid, ready, one result
// depends on pal_pkg
interface pal_out_if import pal_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [ST_W-1:0]         status;
  logic signed [VAL_W-1:0] element;
  logic [IDX_W-1:0]        element_index;
  logic                    last;

  modport source (output valid, status, element, element_index, last, input ready);
  modport sink   (input valid, status, element, element_index, last, output ready);
endinterface

>>> rtl/core/pal_cell.sv
// one storage cell of the element chain, holding the entry at index IDX
// depends on pal_pkg
module pal_cell import pal_pkg::*; #(
  parameter int IDX = 0
) (
  input  logic             clk,
  input  cell_cmd_t        cmd,
  input  logic [VAL_W-1:0] lower_data,
  input  logic [VAL_W-1:0] upper_data,
  input  logic [VAL_W-1:0] head_data,
  output logic [VAL_W-1:0] data
);

  localparam logic [POS_W-1:0] MY_IDX = POS_W'(IDX);

  logic [VAL_W-1:0] data_r;
  logic [VAL_W-1:0] data_nxt;

  // insert shifts up above pos, delete shifts down from pos,
  // rotate moves the cells below pos down and wraps the head into the top used cell
  always_comb begin
    data_nxt = data_r;
    unique case (cmd.act)
      ACT_INSERT: begin
        if (MY_IDX > cmd.pos) data_nxt = lower_data;
        else if (MY_IDX == cmd.pos) data_nxt = cmd.value;
      end
      ACT_DELETE: begin
        if (MY_IDX >= cmd.pos) data_nxt = upper_data;
      end
      ACT_ROTATE: begin
        if (MY_IDX < cmd.pos) data_nxt = upper_data;
        else if (MY_IDX == cmd.pos) data_nxt = head_data;
      end
      default: data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;

endmodule

>>> rtl/core/positional_array_list.sv
// top level of the positional array list: control, result register, cell chain
// depends on pal_pkg, pal_in_if, pal_out_if, pal_cell and the defines header
//
//   channel  direction  payload
//   in_ch    sink       operation, value, position, last_of_set, no_element
//   out_ch   source     status, element, element_index, last
//
// create, insert and delete shift the whole chain at once, and the single result
// lands in the output register at the edge that accepts the operation.
// display enters the display state, which sends the elements one by one, read
// from cell 0 while the used part of the chain rotates down by one.
// rst_n clears control state only; stored elements need no clearing.
// a stalled output holds the result register and blocks new transfers.
`include "positional_array_list_defines.svh"

module positional_array_list import pal_pkg::*; #(
  parameter int DEPTH = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  pal_in_if.sink     in_ch,
  pal_out_if.source  out_ch
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int DW = $clog2(DEPTH);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  typedef enum logic {S_IDLE, S_DISPLAY} state_t;

  state_t            state_r, state_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic              created_r, created_nxt;
  logic              loading_r, loading_nxt;
  logic [DW-1:0]     disp_r, disp_nxt;
  logic              out_valid_r, out_valid_nxt;
  status_t           out_status_r, out_status_nxt;
  logic [VAL_W-1:0]  out_elem_r, out_elem_nxt;
  logic [IDX_W-1:0]  out_idx_r, out_idx_nxt;
  logic              out_last_r, out_last_nxt;

  cell_cmd_t         cmd;
  logic [VAL_W-1:0]  cell_data [DEPTH];
  logic              slot_free;
  logic              in_xfer;
  logic              disp_emit;
  logic              disp_last;
  logic              is_full;
  logic [POS_W-1:0]  count_pos;
  op_t               op;

  assign slot_free = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE) && slot_free;
  assign in_xfer = in_ch.valid && in_ch.ready;
  assign disp_emit = (state_r == S_DISPLAY) && slot_free;
  assign disp_last = (CW'(disp_r) + CW'(1)) == count_r;
  assign is_full = count_r == FULL_CNT;
  assign count_pos = POS_W'(count_r);
  assign op = op_t'(in_ch.operation);

  // operation decode and next-state logic
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    created_nxt    = created_r;
    loading_nxt    = loading_r;
    disp_nxt       = disp_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_status_nxt = out_status_r;
    out_elem_nxt   = out_elem_r;
    out_idx_nxt    = out_idx_r;
    out_last_nxt   = out_last_r;
    cmd.act        = ACT_HOLD;
    cmd.pos        = in_ch.position;
    cmd.value      = in_ch.value;

    if (in_xfer) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = ST_OK;
      out_elem_nxt   = '0;
      out_idx_nxt    = '0;
      out_last_nxt   = 1'b1;
      if (op == OP_CREATE) begin
        if (created_r) begin
          out_status_nxt = ST_ALREADY;
        end else begin
          loading_nxt = 1'b1;
          if (!in_ch.no_element) begin
            if (is_full) begin
              out_status_nxt = ST_FULL;
            end else begin
              cmd.act   = ACT_INSERT;
              cmd.pos   = count_pos;
              count_nxt = count_r + CW'(1);
            end
          end
          if (in_ch.last_of_set) begin
            created_nxt = 1'b1;
            loading_nxt = 1'b0;
          end
        end
      end else if (!created_r) begin
        out_status_nxt = ST_NOT_CREATED;
      end else begin
        unique case (op)
          OP_DISPLAY: begin
            if (count_r == '0) begin
              out_status_nxt = ST_EMPTY;
            end else begin
              // results come from the display state instead
              out_valid_nxt = 1'b0;
              state_nxt     = S_DISPLAY;
              disp_nxt      = '0;
            end
          end
          OP_INSERT: begin
            if (in_ch.position > count_pos) begin
              out_status_nxt = ST_BAD_POS;
            end else if (is_full) begin
              out_status_nxt = ST_FULL;
            end else begin
              cmd.act   = ACT_INSERT;
              count_nxt = count_r + CW'(1);
            end
          end
          OP_DELETE: begin
            if (count_r == '0) begin
              out_status_nxt = ST_EMPTY;
            end else if (in_ch.position >= count_pos) begin
              out_status_nxt = ST_BAD_POS;
            end else begin
              cmd.act   = ACT_DELETE;
              count_nxt = count_r - CW'(1);
            end
          end
          default: out_status_nxt = ST_OK;
        endcase
      end
    end else if (disp_emit) begin
      // read the head and rotate the used cells down by one
      out_valid_nxt  = 1'b1;
      out_status_nxt = ST_OK;
      out_elem_nxt   = cell_data[0];
      out_idx_nxt    = IDX_W'(disp_r);
      out_last_nxt   = disp_last;
      cmd.act        = ACT_ROTATE;
      cmd.pos        = count_pos - POS_W'(1);
      if (disp_last) begin
        state_nxt = S_IDLE;
      end else begin
        disp_nxt = disp_r + DW'(1);
      end
    end
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      created_r   <= 1'b0;
      loading_r   <= 1'b0;
      disp_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      created_r   <= created_nxt;
      loading_r   <= loading_nxt;
      disp_r      <= disp_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_status_r <= out_status_nxt;
    out_elem_r   <= out_elem_nxt;
    out_idx_r    <= out_idx_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = out_status_r;
  assign out_ch.element       = out_elem_r;
  assign out_ch.element_index = out_idx_r;
  assign out_ch.last          = out_last_r;

  // element chain
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [VAL_W-1:0] lower_d;
    logic [VAL_W-1:0] upper_d;
    if (i == 0) begin : g_bottom
      assign lower_d = cmd.value;
    end else begin : g_lower
      assign lower_d = cell_data[i-1];
    end
    if (i == DEPTH - 1) begin : g_top
      assign upper_d = cell_data[i];
    end else begin : g_upper
      assign upper_d = cell_data[i+1];
    end
    pal_cell #(.IDX(i)) u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .lower_data (lower_d),
      .upper_data (upper_d),
      .head_data  (cell_data[0]),
      .data       (cell_data[i])
    );
  end

  // checks
  `PAL_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, count_r <= FULL_CNT)
  `PAL_ASSERT_IMP(a_created_loading, clk, rst_n, created_r, !loading_r)
  `PAL_ASSERT_IMP(a_display_blocks_in, clk, rst_n, state_r == S_DISPLAY, !in_ch.ready)
  `PAL_ASSERT_NXT(a_display_ends, clk, rst_n, disp_emit && disp_last, state_r == S_IDLE)

endmodule

>>> sim/testbench.sv
// self-checking testbench for the positional array list
// depends on pal_pkg, pal_in_if, pal_out_if and the positional_array_list top level
// drives list operations from a queue and checks every result against a local list model
module testbench import pal_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH        = 64;
  localparam int RANDOM_ITEMS = 290;
  localparam int GAP_MAX      = 11;
  localparam int SETTLE_CYCLES = 2 * DEPTH + 8;
  localparam int MAX_REPORTS  = 10;

  typedef struct {
    op_t                     op;
    logic signed [VAL_W-1:0] value;
    logic [POS_W-1:0]        pos;
    logic                    last_set;
    logic                    none;
    bit                      settle;
  } list_op_t;

  typedef struct {
    status_t                 status;
    logic signed [VAL_W-1:0] element;
    logic [IDX_W-1:0]        elem_idx;
    logic                    is_last;
  } list_result_t;

  typedef enum {WALK_DRAIN, WALK_FILL, WALK_MIX} walk_t;

  logic clk = 1'b0;
  logic rst_n;

  pal_in_if  in_ch ();
  pal_out_if out_ch ();

  positional_array_list #(.DEPTH(DEPTH)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #5 clk = ~clk;

  // operations waiting to be sent and results waiting to arrive
  list_op_t     pending_ops[$];
  list_result_t expected_results[$];

  // local copy of the list
  logic signed [VAL_W-1:0] list_vals [DEPTH];
  int unsigned list_len  = 0;
  bit          list_made = 1'b0;

  // count tracked while the stimulus is built
  int unsigned plan_len  = 0;
  bit          plan_made = 1'b0;

  int n_errors  = 0;
  int n_results = 0;
  int n_ops     = 0;
  int op_seen [4];
  int hit_full  = 0;
  int hit_empty = 0;

  // idle draw with occasional stretches of no idling
  function automatic int draw_wait(ref int quiet_left);
    if (quiet_left > 0) begin
      quiet_left--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      quiet_left = $urandom_range(8, 30);
      return 0;
    end
    return $urandom_range(0, GAP_MAX);
  endfunction

  function automatic logic signed [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 15))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2:       return '0;
      3:       return -32'sd1;
      default: return $urandom();
    endcase
  endfunction

  // mostly legal positions, some at the ends, some anywhere in range
  function automatic logic [POS_W-1:0] pick_pos(int limit);
    if (limit < 0 || $urandom_range(0, 7) == 0) return POS_W'($urandom_range(0, DEPTH));
    if ($urandom_range(0, 4) == 0) return ($urandom_range(0, 1) != 0) ? POS_W'(limit) : '0;
    return POS_W'($urandom_range(0, limit));
  endfunction

  function automatic void plan_op(op_t op, logic signed [VAL_W-1:0] value,
                                  logic [POS_W-1:0] pos, logic last_set,
                                  logic none, bit settle);
    list_op_t t;
    t = '{op: op, value: value, pos: pos, last_set: last_set, none: none,
          settle: settle};
    pending_ops.push_back(t);
    // track the length so later positions can be aimed
    case (op)
      OP_CREATE: if (!plan_made) begin
        if (!none && plan_len < DEPTH) plan_len++;
        if (last_set) plan_made = 1'b1;
      end
      OP_INSERT: if (plan_made && pos <= plan_len && plan_len < DEPTH) plan_len++;
      OP_DELETE: if (plan_made && plan_len > 0 && pos < plan_len) plan_len--;
      default: ;
    endcase
  endfunction

  // one random operation after creation, weights in percent
  function automatic void plan_random(int w_ins, int w_del, int w_disp);
    int  roll;
    bit  settle;
    roll   = $urandom_range(0, 99);
    settle = ($urandom_range(0, 39) == 0);
    if (roll < w_ins)
      plan_op(OP_INSERT, pick_value(), pick_pos(plan_len), 1'($urandom_range(0, 1)),
              1'($urandom_range(0, 1)), settle);
    else if (roll < w_ins + w_del)
      plan_op(OP_DELETE, pick_value(), pick_pos(int'(plan_len) - 1),
              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), settle);
    else if (roll < w_ins + w_del + w_disp)
      plan_op(OP_DISPLAY, pick_value(), pick_pos(DEPTH), 1'($urandom_range(0, 1)),
              1'($urandom_range(0, 1)), settle);
    else
      plan_op(OP_CREATE, pick_value(), pick_pos(DEPTH), 1'($urandom_range(0, 1)),
              1'($urandom_range(0, 1)), settle);
  endfunction

  // work out the results of one accepted operation and update the list
  function automatic void list_apply(list_op_t t);
    list_result_t r;
    r = '{status: ST_OK, element: '0, elem_idx: '0, is_last: 1'b1};
    n_ops++;
    op_seen[t.op]++;
    if (t.op == OP_CREATE) begin
      if (list_made) begin
        r.status = ST_ALREADY;
      end else begin
        if (!t.none) begin
          if (list_len >= DEPTH) begin
            r.status = ST_FULL;
          end else begin
            list_vals[list_len] = t.value;
            list_len++;
          end
        end
        if (t.last_set) list_made = 1'b1;
      end
    end else if (!list_made) begin
      r.status = ST_NOT_CREATED;
    end else if (t.op == OP_DISPLAY) begin
      if (list_len == 0) begin
        r.status = ST_EMPTY;
      end else begin
        // one result per element, last flag on the final one
        for (int k = 0; k < list_len; k++) begin
          r.element  = list_vals[k];
          r.elem_idx = IDX_W'(k);
          r.is_last  = (k + 1 == list_len);
          expected_results.push_back(r);
        end
        return;
      end
    end else if (t.op == OP_INSERT) begin
      if (t.pos > list_len) begin
        r.status = ST_BAD_POS;
      end else if (list_len >= DEPTH) begin
        r.status = ST_FULL;
      end else begin
        for (int k = list_len; k > t.pos; k--) list_vals[k] = list_vals[k-1];
        list_vals[t.pos] = t.value;
        list_len++;
      end
    end else begin
      if (list_len == 0) begin
        r.status = ST_EMPTY;
      end else if (t.pos >= list_len) begin
        r.status = ST_BAD_POS;
      end else begin
        for (int k = t.pos; k + 1 < list_len; k++) list_vals[k] = list_vals[k+1];
        list_len--;
      end
    end
    if (r.status == ST_FULL)  hit_full++;
    if (r.status == ST_EMPTY) hit_empty++;
    expected_results.push_back(r);
  endfunction

  // driver: sends queued operations with random gaps
  int       in_gap   = 0;
  int       in_quiet = 0;
  list_op_t on_bus;

  always @(posedge clk) begin : driver
    if (!rst_n) begin
      in_ch.valid       <= 1'b0;
      in_ch.operation   <= OP_CREATE;
      in_ch.value       <= '0;
      in_ch.position    <= '0;
      in_ch.last_of_set <= 1'b0;
      in_ch.no_element  <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        list_apply(on_bus);
        in_gap = draw_wait(in_quiet);
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_ch.valid <= 1'b0;
        end else if (pending_ops.size() > 0 &&
                     !(pending_ops[0].settle && expected_results.size() > 0)) begin
          on_bus = pending_ops.pop_front();
          in_ch.valid       <= 1'b1;
          in_ch.operation   <= on_bus.op;
          in_ch.value       <= on_bus.value;
          in_ch.position    <= on_bus.pos;
          in_ch.last_of_set <= on_bus.last_set;
          in_ch.no_element  <= on_bus.none;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks each result transfer against the oldest expectation
  int out_stall = 0;
  int out_quiet = 0;

  always @(posedge clk) begin : monitor
    list_result_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        n_results++;
        if (expected_results.size() == 0) begin
          n_errors++;
          if (n_errors <= MAX_REPORTS)
            $display("unexpected result: status %0d element %0d index %0d last %0b",
                     out_ch.status, out_ch.element, out_ch.element_index, out_ch.last);
        end else begin
          want = expected_results.pop_front();
          if (out_ch.status !== want.status || out_ch.element !== want.element ||
              out_ch.element_index !== want.elem_idx || out_ch.last !== want.is_last) begin
            n_errors++;
            if (n_errors <= MAX_REPORTS)
              $display("mismatch at result %0d: expected %0d/%0d/%0d/%0b, got %0d/%0d/%0d/%0b",
                       n_results, want.status, want.element, want.elem_idx, want.is_last,
                       out_ch.status, out_ch.element, out_ch.element_index, out_ch.last);
          end
        end
        out_stall = draw_wait(out_quiet);
      end
      if (out_stall > 0) begin
        out_stall--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // stimulus, reset and end of run
  initial begin : stimulus
    walk_t walk;
    int    n_rand;
    int    at_end;
    rst_n = 1'b0;

    // operations before any create
    plan_op(OP_DISPLAY, 0, 0, 1'b0, 1'b0, 1'b0);
    plan_op(OP_INSERT,  5, 0, 1'b0, 1'b0, 1'b0);
    plan_op(OP_DELETE,  0, 0, 1'b0, 1'b0, 1'b0);
    // empty append opens creation, other operations still refused
    plan_op(OP_CREATE,  0, 0, 1'b0, 1'b1, 1'b0);
    plan_op(OP_DISPLAY, 0, 0, 1'b0, 1'b0, 1'b0);
    plan_op(OP_INSERT,  7, 0, 1'b0, 1'b0, 1'b0);
    plan_op(OP_DELETE,  0, 0, 1'b0, 1'b0, 1'b0);
    // value extremes
    plan_op(OP_CREATE, 32'sh8000_0000, 0, 1'b0, 1'b0, 1'b0);
    plan_op(OP_CREATE, 32'sh7fff_ffff, 0, 1'b0, 1'b0, 1'b0);
    plan_op(OP_CREATE, 0,              0, 1'b0, 1'b0, 1'b0);
    plan_op(OP_CREATE, -1,             0, 1'b0, 1'b0, 1'b0);
    plan_op(OP_CREATE, 32'sh5555_5555, 0, 1'b0, 1'b0, 1'b0);
    plan_op(OP_CREATE, 32'shaaaa_aaaa, 0, 1'b0, 1'b0, 1'b0);
    // fill to capacity with random values
    while (plan_len < DEPTH)
      plan_op(OP_CREATE, pick_value(), pick_pos(DEPTH), 1'b0, 1'b0, 1'b0);
    // create with no room, then one that closes creation while full
    plan_op(OP_CREATE, 32'sh1234_5678, 0, 1'b0, 1'b0, 1'b0);
    plan_op(OP_CREATE, 32'sh0bad_f00d, 0, 1'b1, 1'b0, 1'b0);
    // after creation: late create, full display, full and bad positions
    plan_op(OP_CREATE,  9,  0,     1'b1, 1'b0, 1'b1);
    plan_op(OP_DISPLAY, 0,  0,     1'b0, 1'b0, 1'b0);
    plan_op(OP_INSERT,  11, POS_W'(DEPTH), 1'b0, 1'b0, 1'b0);
    plan_op(OP_INSERT,  12, 10,    1'b0, 1'b0, 1'b0);
    plan_op(OP_DELETE,  0,  POS_W'(DEPTH), 1'b0, 1'b0, 1'b0);
    plan_op(OP_DELETE,  0,  POS_W'(DEPTH - 1), 1'b0, 1'b0, 1'b0);
    plan_op(OP_DELETE,  0,  0,     1'b0, 1'b0, 1'b0);
    plan_op(OP_INSERT,  13, POS_W'(DEPTH), 1'b0, 1'b0, 1'b0);
    plan_op(OP_INSERT,  -14, POS_W'(DEPTH - 2), 1'b0, 1'b0, 1'b0);
    plan_op(OP_DISPLAY, 0,  0,     1'b0, 1'b0, 1'b0);

    // random walk: drain to empty, refill to full, then mixed traffic
    walk   = WALK_DRAIN;
    at_end = 0;
    n_rand = 0;
    while (n_rand < RANDOM_ITEMS) begin
      case (walk)
        WALK_DRAIN: begin
          if (plan_len > 0) begin
            plan_random(10, 70, 12);
          end else begin
            // corner cases at the empty list
            case (at_end)
              0: plan_op(OP_DISPLAY, 0, 0, 1'b1, 1'b1, 1'b1);
              1: plan_op(OP_DELETE, 0, pick_pos(DEPTH), 1'b0, 1'b0, 1'b0);
              2: plan_op(OP_INSERT, pick_value(), POS_W'($urandom_range(1, DEPTH)),
                         1'b0, 1'b0, 1'b0);
              default: begin
                plan_op(OP_INSERT, pick_value(), 0, 1'b0, 1'b0, 1'b0);
                walk = WALK_FILL;
              end
            endcase
            at_end = (walk == WALK_FILL) ? 0 : at_end + 1;
          end
        end
        WALK_FILL: begin
          if (plan_len < DEPTH) begin
            plan_random(70, 8, 14);
          end else begin
            // corner cases at the full list
            case (at_end)
              0: plan_op(OP_INSERT, pick_value(), POS_W'(DEPTH), 1'b0, 1'b0, 1'b1);
              1: plan_op(OP_INSERT, pick_value(), pick_pos(DEPTH), 1'b0, 1'b0, 1'b0);
              2: plan_op(OP_DISPLAY, 0, 0, 1'b0, 1'b0, 1'b0);
              default: begin
                plan_op(OP_DELETE, 0, POS_W'(DEPTH), 1'b0, 1'b0, 1'b0);
                walk = WALK_MIX;
              end
            endcase
            at_end++;
          end
        end
        default: plan_random(35, 35, 20);
      endcase
      n_rand++;
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // wait for the last operation to be sent and its results to arrive
    @(negedge clk);
    while (pending_ops.size() > 0 || in_ch.valid || expected_results.size() > 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("ran %0d operations (create %0d, display %0d, insert %0d, delete %0d)",
             n_ops, op_seen[OP_CREATE], op_seen[OP_DISPLAY], op_seen[OP_INSERT],
             op_seen[OP_DELETE]);
    $display("checked %0d results; list full %0d times, empty %0d times, %0d errors",
             n_results, hit_full, hit_empty, n_errors);
    if (n_errors == 0 && expected_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // timeout far beyond the slowest legal run
  initial begin : watchdog
    #20_000_000;
    $display("timeout with %0d results still expected", expected_results.size());
    $display("CHECK FAILED");
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/pal_pkg.sv
rtl/core/pal_in_if.sv
rtl/core/pal_out_if.sv
rtl/core/pal_cell.sv
rtl/core/positional_array_list.sv
sim/testbench.sv
